// ===== sv/lrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_pkg
// shared types, widths and helpers for the lcg run statistics block
// ----------------------------------------------------------------------------
package lrs_pkg;

	localparam int WORD_BITS = 32;
	localparam int STEP_BITS = 21;
	localparam int STEP_MAX  = 1 << 20;
	localparam int REM_BITS  = $clog2(STEP_MAX);
	localparam int NBITS_W   = 5;
	localparam int DIST_W    = $clog2(WORD_BITS + 1);
	localparam int CFG_IDX_W = 2;
	localparam int Q_DEPTH   = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_COUNT    = 2'd0,
		CFG_INTERVAL_LOW  = 2'd1,
		CFG_INTERVAL_HIGH = 2'd2,
		CFG_TARGET_WORD   = 2'd3
	} cfg_idx_t;

	typedef logic [WORD_BITS-1:0] word_t;

	// one classified job as it sits in the queue
	typedef struct packed {
		word_t               multiplier;
		word_t               increment;
		word_t               keep;
		logic [REM_BITS-1:0] steps_m1;
	} job_t;

	typedef struct packed {
		logic [STEP_BITS-1:0] step_count;
		word_t                interval_low;
		word_t                interval_high;
		word_t                target_word;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// low n bits set, clipped to the word
	function automatic word_t keep_mask(input logic [NBITS_W-1:0] n);
		word_t m;
		m = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			m[i] = (i < int'(n));
		end
		return m;
	endfunction

	// zero runs as one step, large counts saturate
	function automatic logic [REM_BITS-1:0] steps_minus_one(input logic [STEP_BITS-1:0] sc);
		logic [REM_BITS-1:0] r;
		if (sc == '0) begin
			r = '0;
		end else if (sc > STEP_BITS'(STEP_MAX)) begin
			r = REM_BITS'(STEP_MAX - 1);
		end else begin
			r = REM_BITS'(sc - 1'b1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/lrs_job_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_job_if
// job request channel: multiplier, increment and modulus exponent
// ----------------------------------------------------------------------------
interface lrs_job_if;
	logic                         valid;
	logic                         ready;
	lrs_pkg::word_t               multiplier;
	lrs_pkg::word_t               increment;
	logic [lrs_pkg::NBITS_W-1:0]  modulus_bits;

	modport source(output valid, multiplier, increment, modulus_bits, input ready);
	modport sink(input valid, multiplier, increment, modulus_bits, output ready);
endinterface
`default_nettype wire

// ===== sv/lrs_result_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_result_if
// result channel: in-range count and distance extremes of one job
// ----------------------------------------------------------------------------
interface lrs_result_if;
	logic                          valid;
	logic                          ready;
	logic [lrs_pkg::STEP_BITS-1:0] in_range_count;
	logic [lrs_pkg::DIST_W-1:0]    min_distance;
	logic [lrs_pkg::DIST_W-1:0]    max_distance;

	modport source(output valid, in_range_count, min_distance, max_distance, input ready);
	modport sink(input valid, in_range_count, min_distance, max_distance, output ready);
endinterface
`default_nettype wire

// ===== sv/lrs_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_cfg_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
interface lrs_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lrs_pkg::CFG_IDX_W-1:0] index;
	lrs_pkg::word_t                data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/lcg_run_statistics.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_run_statistics
// linear congruential generator jobs with in-range count and distance stats
// ----------------------------------------------------------------------------
// Each job request carries a multiplier, an increment and a modulus exponent.
// From seed zero the block runs x = (a*x + b) mod 2^n for the configured step
// count (zero runs one step, anything above 2^20 runs 2^20 steps), counts the
// values inside [interval_low, interval_high] and keeps the smallest and
// largest Hamming distance to target_word; one result per job. The back end
// runs one generator step per clock, paced by the 32x32 multiply-add that
// feeds the state register back into itself; after its last step a job
// drains the statistics stages and hands off its result before the next. The
// front end registers and classifies requests and a two-entry queue lets it
// keep taking requests while a job runs or a result waits to be taken.
// Registers may be written only while no job is in flight.

module lcg_run_statistics (
	input  wire logic     clk,
	input  wire logic     arst_n,
	lrs_job_if.sink       job,
	lrs_result_if.source  result,
	lrs_cfg_if.sink       cfg
);

	// register file contents; the user must keep them stable while jobs run, the block does not enforce it
	lrs_pkg::cfg_t      cfg_regs;

	// front to queue
	logic               push_valid;
	lrs_pkg::job_t      push_data;

	// queue to back
	lrs_pkg::job_t      pop_data;
	logic               pop_en;
	lrs_pkg::q_status_t qs;

	lrs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	// request intake: mask from the exponent, clamped step count
	lrs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job),
		.cfg        (cfg_regs),
		.qs         (qs),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	lrs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.pop_en     (pop_en),
		.pop_data   (pop_data),
		.qs         (qs)
	);

	// generator loop, statistics pipeline and result register
	lrs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_regs),
		.qs       (qs),
		.pop_data (pop_data),
		.pop_en   (pop_en),
		.result   (result)
	);

endmodule
`default_nettype wire

// ===== sv/lrs_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_cfg
// configuration register file
// ----------------------------------------------------------------------------
module lrs_cfg (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lrs_cfg_if.sink     cfg,
	output lrs_pkg::cfg_t regs
);

	lrs_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.step_count    <= lrs_pkg::STEP_BITS'(1024);
			regs_q.interval_low  <= '0;
			regs_q.interval_high <= '1;
			regs_q.target_word   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (lrs_pkg::cfg_idx_t'(cfg.index))
				lrs_pkg::CFG_STEP_COUNT:    regs_q.step_count    <= cfg.data[lrs_pkg::STEP_BITS-1:0];
				lrs_pkg::CFG_INTERVAL_LOW:  regs_q.interval_low  <= cfg.data;
				lrs_pkg::CFG_INTERVAL_HIGH: regs_q.interval_high <= cfg.data;
				lrs_pkg::CFG_TARGET_WORD:   regs_q.target_word   <= cfg.data;
				default:                    regs_q <= regs_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/lrs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_front
// accepts job requests, derives value mask and step count, feeds the queue
// ----------------------------------------------------------------------------
module lrs_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	lrs_job_if.sink                 job,
	input  wire lrs_pkg::cfg_t      cfg,
	input  wire lrs_pkg::q_status_t qs,
	output logic                    push_valid,
	output lrs_pkg::job_t           push_data
);

	lrs_pkg::job_t slot_s1;
	logic          slot_v_s1;
	logic          push_ready;

	assign push_ready = !qs.full;
	assign job.ready  = !slot_v_s1 || push_ready;
	assign push_valid = slot_v_s1;
	assign push_data  = slot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_v_s1 <= 1'b0;
		end else if (job.valid && job.ready) begin
			slot_v_s1 <= 1'b1;
		end else if (push_ready) begin
			slot_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job.valid && job.ready) begin
			slot_s1.multiplier <= job.multiplier;
			slot_s1.increment  <= job.increment;
			slot_s1.keep       <= lrs_pkg::keep_mask(job.modulus_bits);
			slot_s1.steps_m1   <= lrs_pkg::steps_minus_one(cfg.step_count);
		end
	end

endmodule
`default_nettype wire

// ===== sv/lrs_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module lrs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	input  wire lrs_pkg::job_t  push_data,
	input  wire logic           pop_en,
	output lrs_pkg::job_t       pop_data,
	output lrs_pkg::q_status_t  qs
);

	localparam int PTR_W = (lrs_pkg::Q_DEPTH > 1) ? $clog2(lrs_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(lrs_pkg::Q_DEPTH + 1);

	lrs_pkg::job_t     mem_q [lrs_pkg::Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;

	assign qs.full  = (count_q == CNT_W'(lrs_pkg::Q_DEPTH));
	assign qs.empty = (count_q == '0);
	assign do_push  = push_valid && !qs.full;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(lrs_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(lrs_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(pop_en);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// ===== sv/lrs_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_back
// runs one generator job a step per cycle and gathers its statistics
// ----------------------------------------------------------------------------
module lrs_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lrs_pkg::cfg_t      cfg,
	input  wire lrs_pkg::q_status_t qs,
	input  wire lrs_pkg::job_t      pop_data,
	output logic                    pop_en,
	lrs_result_if.source            result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FLUSH,
		S_DONE
	} state_t;

	function automatic logic [lrs_pkg::DIST_W-1:0] popcount(input lrs_pkg::word_t v);
		logic [lrs_pkg::DIST_W-1:0] c;
		c = '0;
		for (int i = 0; i < lrs_pkg::WORD_BITS; i++) begin
			c = c + lrs_pkg::DIST_W'(v[i]);
		end
		return c;
	endfunction

	state_t                         state_q;
	lrs_pkg::word_t                 mul_q;
	lrs_pkg::word_t                 inc_q;
	lrs_pkg::word_t                 keep_q;
	logic [lrs_pkg::REM_BITS-1:0]   rem_q;
	lrs_pkg::word_t                 x_q;
	lrs_pkg::word_t                 prod_lo;
	lrs_pkg::word_t                 x_next;
	logic                           step_v_q;
	logic                           v_s1;
	logic                           in_s1;
	logic [lrs_pkg::DIST_W-1:0]     dist_s1;
	logic [lrs_pkg::STEP_BITS-1:0]  cnt_q;
	logic [lrs_pkg::DIST_W-1:0]     dmin_q;
	logic [lrs_pkg::DIST_W-1:0]     dmax_q;
	logic                           res_valid_q;
	logic [lrs_pkg::STEP_BITS-1:0]  res_cnt_q;
	logic [lrs_pkg::DIST_W-1:0]     res_min_q;
	logic [lrs_pkg::DIST_W-1:0]     res_max_q;
	logic                           res_load;

	assign pop_en   = (state_q == S_IDLE) && !qs.empty;
	assign res_load = (state_q == S_DONE) && (!res_valid_q || result.ready);

	// low word of the product is all that survives the mask
	assign prod_lo = mul_q * x_q;
	assign x_next  = (prod_lo + inc_q) & keep_q;

	assign result.valid          = res_valid_q;
	assign result.in_range_count = res_cnt_q;
	assign result.min_distance   = res_min_q;
	assign result.max_distance   = res_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_v_q    <= 1'b0;
			v_s1        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			step_v_q <= (state_q == S_RUN);
			v_s1     <= step_v_q;
			// a new result may replace one taken in the same cycle
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!qs.empty) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (rem_q == '0) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (!step_v_q && !v_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop_en) begin
			mul_q  <= pop_data.multiplier;
			inc_q  <= pop_data.increment;
			keep_q <= pop_data.keep;
			rem_q  <= pop_data.steps_m1;
			x_q    <= '0;
			cnt_q  <= '0;
			dmin_q <= '1;
			dmax_q <= '0;
		end
		if (state_q == S_RUN) begin
			x_q   <= x_next;
			rem_q <= rem_q - 1'b1;
		end
		if (step_v_q) begin
			in_s1   <= (x_q >= cfg.interval_low) && (x_q <= cfg.interval_high);
			dist_s1 <= popcount(x_q ^ cfg.target_word);
		end
		if (v_s1) begin
			cnt_q <= cnt_q + lrs_pkg::STEP_BITS'(in_s1);
			if (dist_s1 < dmin_q) begin
				dmin_q <= dist_s1;
			end
			if (dist_s1 > dmax_q) begin
				dmax_q <= dist_s1;
			end
		end
		if (res_load) begin
			res_cnt_q <= cnt_q;
			res_min_q <= dmin_q;
			res_max_q <= dmax_q;
		end
	end

endmodule
`default_nettype wire

// ===== sv/lrs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lrs_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
module lrs_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          res_valid,
	input wire logic                          res_ready,
	input wire logic [lrs_pkg::STEP_BITS-1:0] in_range_count,
	input wire logic [lrs_pkg::DIST_W-1:0]    min_distance,
	input wire logic [lrs_pkg::DIST_W-1:0]    max_distance
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result request dropped while stalled");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> min_distance <= max_distance)
		else $error("min distance above max distance");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (max_distance <= lrs_pkg::DIST_W'(lrs_pkg::WORD_BITS)))
		else $error("distance beyond word width");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (in_range_count <= lrs_pkg::STEP_BITS'(lrs_pkg::STEP_MAX)))
		else $error("count beyond step limit");

endmodule

bind lcg_run_statistics lrs_checker u_lrs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.in_range_count (result.in_range_count),
	.min_distance   (result.min_distance),
	.max_distance   (result.max_distance)
);
`default_nettype wire
